// ----- rtl/core/upr_pkg.sv -----
package upr_pkg;

	// Measurement phases.
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_TRIG_LO    = 3'd1,
		PH_TRIG_HI    = 3'd2,
		PH_WAIT_CLEAR = 3'd3,
		PH_WAIT_RISE  = 3'd4,
		PH_ECHO       = 3'd5
	} phase_t;

	localparam int TICK_W = 15;
	localparam int CM_W   = 9;
	localparam int DIST_W = 8;

	localparam logic [TICK_W-1:0] TRIG_LO_TICKS = 15'd4;
	localparam logic [TICK_W-1:0] TRIG_HI_TICKS = 15'd10;
	localparam logic [TICK_W-1:0] OVERHEAD_US   = 15'd5;
	localparam logic [5:0]        RT_CM         = 6'd57;
	localparam logic [TICK_W-1:0] RT_CM_HALF    = 15'd28;
	localparam int                RT_IN         = 146;

	// Division by RT_IN as a multiply by a scaled reciprocal. The rounding error
	// of the reciprocal stays below one quotient step for every echo width.
	localparam int                DIV_SHIFT = 22;
	localparam logic [TICK_W-1:0] DIV_MUL   = 15'(((1 << DIV_SHIFT) + RT_IN - 1) / RT_IN);

endpackage

// ----- rtl/core/ultrasonic_ping_ranger_unit.sv -----
// Ultrasonic ping ranger. Every input transfer is one microsecond tick carrying the
// sampled echo level and an action bit; every tick yields exactly one result transfer
// with the trigger level, busy and done flags, a no-echo flag and the distance in
// inches. A tick with action 1 while idle starts a measurement: the trigger is held
// low for 4 ticks, high for 10 ticks, then the block waits for the echo to clear and
// rise within START_TIMEOUT_US ticks and times the echo pulse against the limit
// min(max_distance_cm, MAX_RANGE_CM) * 57 + 28 ticks. The reported distance is
// (width - 5) / 146 inches, floored at 0. One tick is accepted in every clock cycle unless
// in_stall holds it off; a tick passes through an input register and a result register,
// so its result is valid once the result register holds it and can be taken at the next clock
// edge at the earliest. A one-entry input register lets the block take a tick while
// the previous result is still waiting to be taken. The range limit is computed when
// max_distance_cm is written, which must happen only while no tick is in flight; the
// new limit applies from the next tick on, also in the middle of a measurement.
module ultrasonic_ping_ranger_unit #(
	parameter int START_TIMEOUT_US = 18000,
	parameter int MAX_RANGE_CM     = 500
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] max_distance_cm,
	// Tick input channel.
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic       echo_level,
	// Result channel.
	output logic       out_valid,
	input  logic       out_stall,
	output logic       trigger_level,
	output logic       busy_res,
	output logic       done_res,
	output logic       no_echo,
	output logic [7:0] distance_inches
);
	import upr_pkg::*;

	localparam logic [TICK_W-1:0] START_TMO = TICK_W'(START_TIMEOUT_US);
	localparam logic [CM_W-1:0]   MAX_CM    = CM_W'(MAX_RANGE_CM);
	localparam logic [TICK_W-1:0] RESET_LIMIT =
		TICK_W'(MAX_RANGE_CM * 57 + 28);

	// Echo width limit, recomputed on every configuration transfer.
	logic [TICK_W-1:0] limit_q;
	logic [CM_W-1:0]   cfg_cm;

	assign cfg_ready = 1'b1;
	assign cfg_cm    = (max_distance_cm > MAX_CM) ? MAX_CM : max_distance_cm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RESET_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= TICK_W'(cfg_cm) * TICK_W'(RT_CM) + RT_CM_HALF;
		end
	end

	// Input register stage.
	logic valid_s1, action_s1, echo_s1;
	logic adv;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			echo_s1   <= echo_level;
		end
	end

	// Measurement state, advanced once per tick as the tick moves to the result register.
	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		case (phase_q)
			PH_TRIG_LO: begin
				tick_d = tick_q + 1'b1;
				if (tick_d >= TRIG_LO_TICKS) begin
					phase_d = PH_TRIG_HI;
					tick_d  = '0;
				end
			end
			PH_TRIG_HI: begin
				tick_d = tick_q + 1'b1;
				if (tick_d >= TRIG_HI_TICKS) begin
					phase_d = PH_WAIT_CLEAR;
					tick_d  = '0;
				end
			end
			PH_WAIT_CLEAR: begin
				// If the echo never clears, the timeout hands over to wait rise.
				if (!echo_s1 || tick_q >= START_TMO) begin
					phase_d = PH_WAIT_RISE;
				end
				if (tick_q < START_TMO) begin
					tick_d = tick_q + 1'b1;
				end
			end
			PH_WAIT_RISE: begin
				if (echo_s1) begin
					phase_d = PH_ECHO;
					tick_d  = TICK_W'(1);
				end else if (tick_q >= START_TMO) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end else begin
					tick_d = tick_q + 1'b1;
				end
			end
			PH_ECHO: begin
				if (echo_s1 && tick_q < limit_q) begin
					tick_d = tick_q + 1'b1;
				end else begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			default: begin
				// Idle, and any unknown code, may start a new measurement.
				phase_d = PH_IDLE;
				tick_d  = '0;
				if (action_s1) begin
					phase_d = PH_TRIG_LO;
					tick_d  = TICK_W'(1);
				end
			end
		endcase
	end

	// Result fields of the tick being processed.
	logic                  trig_c, done_c, noecho_c;
	logic [DIST_W-1:0]     dist_c;
	logic [TICK_W-1:0]     width_c;
	logic [2*TICK_W-1:0]   prod_c;

	assign width_c = tick_q - OVERHEAD_US;
	assign prod_c  = width_c * DIV_MUL;

	always_comb begin
		trig_c   = 1'b0;
		done_c   = 1'b0;
		noecho_c = 1'b0;
		dist_c   = '0;
		case (phase_q)
			PH_TRIG_HI: begin
				trig_c = 1'b1;
			end
			PH_WAIT_RISE: begin
				if (!echo_s1 && tick_q >= START_TMO) begin
					done_c   = 1'b1;
					noecho_c = 1'b1;
				end
			end
			PH_ECHO: begin
				if (echo_s1) begin
					if (tick_q >= limit_q) begin
						done_c   = 1'b1;
						noecho_c = 1'b1;
					end
				end else begin
					// The echo has fallen; short pulses read as zero inches.
					done_c = 1'b1;
					if (tick_q > OVERHEAD_US) begin
						dist_c = prod_c[DIV_SHIFT +: DIST_W];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trigger_level   <= trig_c;
			busy_res        <= (phase_d != PH_IDLE);
			done_res        <= done_c;
			no_echo         <= noecho_c;
			distance_inches <= dist_c;
		end
	end

endmodule

// ----- rtl/core/upr_checker.sv -----
module upr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       trigger_level,
	input logic       busy_res,
	input logic       done_res,
	input logic       no_echo,
	input logic [7:0] distance_inches
);

	// A finishing tick never leaves the block busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done result with busy set");

	// No-echo comes only with done and carries no distance.
	a_noecho_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_echo |-> done_res && distance_inches == 8'd0)
		else $error("no_echo without done or with a distance");

	// The trigger is only driven during a measurement.
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_level |-> busy_res && !done_res)
		else $error("trigger driven outside a measurement");

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_inches)
			&& $stable(done_res) && $stable(busy_res))
		else $error("stalled result changed");

	// The input is only held off while a result waits to be taken.
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with the result register free");

endmodule

bind ultrasonic_ping_ranger_unit upr_checker u_upr_checker (.*);
